// ----- rtl/qualified_state_panel_driver_top_assert.svh -----
// Assertion macros for the qualified state panel driver.
// Used by qualified_state_panel_driver_top; expects clk and rst_n in scope.
`ifndef QUALIFIED_STATE_PANEL_DRIVER_TOP_ASSERT_SVH
`define QUALIFIED_STATE_PANEL_DRIVER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check outside reset
`define QSPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also covers the reset cycles
`define QSPD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSPD_ASSERT(lbl, prop, msg)
`define QSPD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/qspd_pkg.sv -----
// Package for the qualified state panel driver: payload types, state codes,
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
package qspd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // vehicle state codes
  localparam logic [3:0] ST_ROOT        = 4'd0;
  localparam logic [3:0] ST_LV          = 4'd1;
  localparam logic [3:0] ST_PRECHARGING = 4'd2;
  localparam logic [3:0] ST_READY       = 4'd3;
  localparam logic [3:0] ST_DRIVING     = 4'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTRO_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd2;

  localparam logic [CFG_DATA_W-1:0] INTRO_TIME_RST   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] BUZZ_LENGTH_RST  = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] BLINK_PERIOD_RST = 16'd500;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  reported_state;
  } qspd_in_t;

  typedef struct packed {
    logic       buzzer_on;
    logic       ready_led_on;
    logic       reset_led_on;
    logic [3:0] accepted_state;
  } qspd_out_t;

endpackage

// ----- rtl/qspd_stream_if.sv -----
// Valid/ready stream interface for the qualified state panel driver.
// Payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps
interface qspd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/qualified_state_panel_driver_top.sv -----
// Qualified state panel driver: state qualification, buzzer pulse, LEDs.
// Depends on qspd_pkg, qspd_stream_if and qualified_state_panel_driver_top_assert.svh.
//
//   channel    | direction | handshake        | payload
//   -----------+-----------+------------------+-----------------------------------------
//   in_stream  | in        | valid / ready    | now_ms[31:0], reported_state[3:0]
//   out_stream | out       | valid / ready    | buzzer_on, ready_led_on, reset_led_on,
//              |           |                  | accepted_state[3:0]
//   cfg_*      | in        | cfg_we only      | cfg_idx[1:0], cfg_wdata[15:0]
//
// One transaction in gives one transaction out, one per clock sustained while
// out_stream is ready. The input register loads at the accepting edge; the
// evaluation stage then writes the result register and the panel state once the
// result register is free. Reset (rst_n low, synchronous) empties both registers and
// loads the default timing registers and the root state. A stalled result register
// holds the input register; in_stream ready stays high while it is empty or drains.
`timescale 1ns / 1ps
`include "qualified_state_panel_driver_top_assert.svh"
module qualified_state_panel_driver_top (
  input  logic                             clk,
  input  logic                             rst_n,
  qspd_stream_if.sink                      in_stream,
  qspd_stream_if.source                    out_stream,
  input  logic                             cfg_we,
  input  logic [qspd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [qspd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import qspd_pkg::*;

  // timing registers
  logic [CFG_DATA_W-1:0] intro_time_r;
  logic [CFG_DATA_W-1:0] buzz_length_r;
  logic [CFG_DATA_W-1:0] blink_period_r;

  // pipeline registers
  logic      in_v_r;
  qspd_in_t  in_r;
  logic      out_v_r;
  qspd_out_t out_r;

  // panel state
  logic [3:0]  last_seen_r, last_seen_nxt;
  logic [3:0]  qual_r, qual_nxt;
  logic [31:0] change_time_r, change_time_nxt;
  logic        was_driving_r, was_driving_nxt;
  logic [31:0] buzz_start_r, buzz_start_nxt;
  logic [31:0] next_blink_r, next_blink_nxt;
  logic        ready_led_r, ready_led_nxt;
  logic        reset_led_r, reset_led_nxt;
  logic        buzz;

  logic out_free;
  logic proc;
  logic driving;
  logic blink_due;
  logic [31:0] held_ms;
  logic [31:0] buzz_ms;

  assign out_free        = !out_v_r || out_stream.ready;
  assign proc            = in_v_r && out_free;
  assign in_stream.ready = !in_v_r || out_free;

  assign out_stream.valid = out_v_r;
  assign out_stream.data  = out_r;

  // configuration writes; index 3 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intro_time_r   <= INTRO_TIME_RST;
      buzz_length_r  <= BUZZ_LENGTH_RST;
      blink_period_r <= BLINK_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INTRO_TIME:   intro_time_r   <= cfg_wdata;
        CFG_BUZZ_LENGTH:  buzz_length_r  <= cfg_wdata;
        CFG_BLINK_PERIOD: blink_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_stream.ready) begin
      in_v_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      in_r <= in_stream.data;
    end
  end

  // evaluation: qualification, buzzer, then LEDs on the newly accepted state
  always_comb begin
    last_seen_nxt   = in_r.reported_state;
    change_time_nxt = (in_r.reported_state != last_seen_r) ? in_r.now_ms : change_time_r;

    // wrapping elapsed time since the reported state last changed
    held_ms  = in_r.now_ms - change_time_nxt;
    qual_nxt = qual_r;
    if ((in_r.reported_state != qual_r) && (held_ms > {16'd0, intro_time_r})) begin
      qual_nxt = in_r.reported_state;
    end

    driving         = (qual_nxt == ST_DRIVING);
    was_driving_nxt = driving;
    buzz_ms         = in_r.now_ms - buzz_start_r;
    buzz_start_nxt  = buzz_start_r;
    buzz            = 1'b0;
    if (driving) begin
      if (was_driving_r) begin
        buzz = (buzz_ms < {16'd0, buzz_length_r});
      end else begin
        buzz_start_nxt = in_r.now_ms;
        buzz           = 1'b1;
      end
    end

    // blink deadline is a plain compare, no wrap handling
    blink_due      = (in_r.now_ms > next_blink_r);
    ready_led_nxt  = ready_led_r;
    reset_led_nxt  = reset_led_r;
    next_blink_nxt = next_blink_r;
    case (qual_nxt)
      ST_ROOT: begin
        ready_led_nxt = 1'b1;
        reset_led_nxt = 1'b1;
      end
      ST_LV: begin
        reset_led_nxt = 1'b0;
        if (blink_due) begin
          ready_led_nxt  = !ready_led_r;
          next_blink_nxt = in_r.now_ms + {16'd0, blink_period_r};
        end
      end
      ST_PRECHARGING: begin
        reset_led_nxt = 1'b0;
        ready_led_nxt = 1'b1;
      end
      ST_READY: begin
        ready_led_nxt = 1'b0;
        if (blink_due) begin
          reset_led_nxt  = !reset_led_r;
          next_blink_nxt = in_r.now_ms + {16'd0, blink_period_r};
        end
      end
      default: begin
        ready_led_nxt = 1'b0;
        reset_led_nxt = 1'b0;
      end
    endcase
  end

  // panel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r   <= ST_ROOT;
      qual_r        <= ST_ROOT;
      change_time_r <= '0;
      was_driving_r <= 1'b0;
      buzz_start_r  <= '0;
      next_blink_r  <= '0;
      ready_led_r   <= 1'b0;
      reset_led_r   <= 1'b0;
    end else if (proc) begin
      last_seen_r   <= last_seen_nxt;
      qual_r        <= qual_nxt;
      change_time_r <= change_time_nxt;
      was_driving_r <= was_driving_nxt;
      buzz_start_r  <= buzz_start_nxt;
      next_blink_r  <= next_blink_nxt;
      ready_led_r   <= ready_led_nxt;
      reset_led_r   <= reset_led_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r.buzzer_on      <= buzz;
      out_r.ready_led_on   <= ready_led_nxt;
      out_r.reset_led_on   <= reset_led_nxt;
      out_r.accepted_state <= qual_nxt;
    end
  end

  `QSPD_ASSERT(a_buzz_only_driving, out_v_r && (out_r.accepted_state != ST_DRIVING) |-> !out_r.buzzer_on, "buzzer on outside driving")
  `QSPD_ASSERT(a_was_driving_tracks, was_driving_r == (qual_r == ST_DRIVING), "was_driving out of step with accepted state")
  `QSPD_ASSERT(a_qual_holds_idle, !proc |=> $stable(qual_r), "accepted state changed without a transaction")
  `QSPD_ASSERT(a_stalled_input_kept, in_v_r && !out_free |=> in_v_r, "stalled input transaction dropped")
  `QSPD_ASSERT_RST(a_reset_empties, !rst_n |=> !in_v_r && !out_v_r, "pipeline not empty after reset")

endmodule
